@@ hdl/hwmc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hot water mode controller package
// Shared types, register indexes, reset values and the 16-bit saturation.
// ----------------------------------------------------------------------------
package hwmc_pkg;

	typedef enum logic [1:0] {
		CMD_NONE   = 2'd0,
		CMD_SET1   = 2'd1,
		CMD_SET10  = 2'd2,
		CMD_SET240 = 2'd3
	} cmd_t;

	localparam logic [2:0] CFG_SETPOINT     = 3'd0;
	localparam logic [2:0] CFG_DELTA        = 3'd1;
	localparam logic [2:0] CFG_OFFSET_START = 3'd2;
	localparam logic [2:0] CFG_STEP         = 3'd3;
	localparam logic [2:0] CFG_DELAY        = 3'd4;

	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;

	localparam logic [7:0] CYCLE_ONE = 8'd1;
	localparam logic [7:0] CYCLE_MAX = 8'd240;
	localparam logic signed [18:0] NEAR_MARGIN = 19'sd20;

	typedef struct packed {
		logic [11:0] setpoint;
		logic [8:0]  delta;
		logic [9:0]  offset_start;
		logic [7:0]  step;
		logic [15:0] delay;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		setpoint:     12'd500,
		delta:        9'd50,
		offset_start: 10'd0,
		step:         8'd20,
		delay:        16'd7200
	};

	typedef struct packed {
		logic [11:0] buffer_temp;
		logic        buffer_temp_valid;
		logic [11:0] return_temp;
		logic        compressor_running;
		logic        defrost_active;
		logic        dip_switch;
		logic [7:0]  present_cycle;
		logic        decade_tick;
		logic        second_tick;
	} item_t;

	typedef struct packed {
		logic [15:0] heating_setpoint;
		logic        element_on;
		logic [1:0]  mode;
		cmd_t        regulation_command;
		cmd_t        mode_command;
	} res_t;

	function automatic logic [15:0] sat16(input logic signed [18:0] v);
		logic [15:0] r;
		if (v > 19'sd32767) begin
			r = 16'h7FFF;
		end else if (v < -19'sd32768) begin
			r = 16'h8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ hdl/hot_water_mode_controller_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hot water mode controller
// Input register, controller core and output register with valid/stall beats.
// ----------------------------------------------------------------------------
// Path: an input beat passes the input reg, then the result reg, to output valid.
// Throughput: 1 beat per cycle unless stalled; state update is one compare/add level.
// Input stall follows output stall only when both registers are full.
// Reset: asynchronous, clears mode to init, offset to the offset_start reset
// value, counters and flags to zero, config registers to their defaults.
module hot_water_mode_controller_unit #(
	parameter int COUNTER_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [15:0]         cfg_wdata,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic signed [11:0]  buffer_temp,
	input  wire logic                buffer_temp_valid,
	input  wire logic signed [11:0]  return_temp,
	input  wire logic                compressor_running,
	input  wire logic                defrost_active,
	input  wire logic                dip_switch,
	input  wire logic [7:0]          present_cycle,
	input  wire logic                decade_tick,
	input  wire logic                second_tick,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic signed [15:0]       heating_setpoint,
	output logic                     element_on,
	output logic [1:0]               mode,
	output logic [1:0]               regulation_command,
	output logic [1:0]               mode_command
);

	hwmc_pkg::cfg_t  cfg_q;
	hwmc_pkg::item_t item_s1;
	logic            valid_s1;
	hwmc_pkg::res_t  res, res_q;
	logic            out_valid_q;
	logic            advance;
	logic            accept;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= hwmc_pkg::CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hwmc_pkg::CFG_SETPOINT:     cfg_q.setpoint     <= cfg_wdata[11:0];
				hwmc_pkg::CFG_DELTA:        cfg_q.delta        <= cfg_wdata[8:0];
				hwmc_pkg::CFG_OFFSET_START: cfg_q.offset_start <= cfg_wdata[9:0];
				hwmc_pkg::CFG_STEP:         cfg_q.step         <= cfg_wdata[7:0];
				hwmc_pkg::CFG_DELAY:        cfg_q.delay        <= cfg_wdata[15:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.buffer_temp        <= buffer_temp;
			item_s1.buffer_temp_valid  <= buffer_temp_valid;
			item_s1.return_temp        <= return_temp;
			item_s1.compressor_running <= compressor_running;
			item_s1.defrost_active     <= defrost_active;
			item_s1.dip_switch         <= dip_switch;
			item_s1.present_cycle      <= present_cycle;
			item_s1.decade_tick        <= decade_tick;
			item_s1.second_tick        <= second_tick;
		end
	end

	hwmc_ctrl #(
		.COUNTER_BITS(COUNTER_BITS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (item_s1),
		.cfg     (cfg_q),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid          = out_valid_q;
	assign heating_setpoint   = res_q.heating_setpoint;
	assign element_on         = res_q.element_on;
	assign mode               = res_q.mode;
	assign regulation_command = res_q.regulation_command;
	assign mode_command       = res_q.mode_command;

endmodule
`default_nettype wire

@@ hdl/hwmc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hot water mode controller core
// Mode state, setpoint offset and run-seconds counter; one beat per step.
// ----------------------------------------------------------------------------
module hwmc_ctrl #(
	parameter int COUNTER_BITS = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step_en,
	input  wire hwmc_pkg::item_t item,
	input  wire hwmc_pkg::cfg_t  cfg,
	output hwmc_pkg::res_t       res
);

	localparam int CMP_W = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;
	localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

	typedef enum logic [1:0] {
		ST_INIT = 2'd0,
		ST_IDLE = 2'd1,
		ST_RUN  = 2'd2,
		ST_ELEM = 2'd3
	} mode_t;

	mode_t                   mode_q, mode_n;
	logic                    element_q, element_n;
	logic [15:0]             offset_q, offset_n;
	logic                    unknown_q, unknown_n;
	logic [COUNTER_BITS-1:0] run_sec_q, run_sec_n, run_sec_inc;
	logic                    stopped_q, stopped_n;
	logic                    prev_dip_q, prev_dip_n;
	logic                    allow_q, allow_n;
	hwmc_pkg::cmd_t          reg_cmd, mode_cmd;

	logic signed [18:0] buf_x, ret_x, sp_x, off_x, delta_x, step_x, ostart_x;
	logic signed [18:0] sp_sum;
	logic               regulate;

	always_comb begin
		buf_x    = {{7{item.buffer_temp[11]}}, item.buffer_temp};
		ret_x    = {{7{item.return_temp[11]}}, item.return_temp};
		sp_x     = {{7{cfg.setpoint[11]}}, cfg.setpoint};
		off_x    = {{3{offset_q[15]}}, offset_q};
		delta_x  = {10'd0, cfg.delta};
		step_x   = {11'd0, cfg.step};
		ostart_x = {{9{cfg.offset_start[9]}}, cfg.offset_start};
		sp_sum   = unknown_q ? sp_x : (sp_x + off_x);
		regulate = ~item.dip_switch;
	end

	always_comb begin
		run_sec_inc = run_sec_q;
		if (item.second_tick && !stopped_q && (run_sec_q != CNT_MAX)) begin
			run_sec_inc = run_sec_q + 1'b1;
		end

		mode_n     = mode_q;
		element_n  = element_q;
		offset_n   = offset_q;
		unknown_n  = unknown_q;
		run_sec_n  = run_sec_inc;
		stopped_n  = stopped_q;
		prev_dip_n = prev_dip_q;
		allow_n    = allow_q;
		reg_cmd    = hwmc_pkg::CMD_NONE;
		mode_cmd   = hwmc_pkg::CMD_NONE;

		if (item.buffer_temp_valid) begin
			if (item.dip_switch != prev_dip_q) begin
				prev_dip_n = item.dip_switch;
				if (item.dip_switch) begin
					reg_cmd = hwmc_pkg::CMD_SET10;
				end
			end

			priority if (item.decade_tick) begin
				allow_n = 1'b1;
			end else if (!regulate) begin
				allow_n = 1'b0;
			end else if (allow_q && (buf_x <= sp_x - delta_x) &&
			             (item.present_cycle != hwmc_pkg::CYCLE_ONE)) begin
				reg_cmd = hwmc_pkg::CMD_SET1;
				allow_n = 1'b0;
			end else if (allow_q && (buf_x >= sp_x) &&
			             (item.present_cycle != hwmc_pkg::CYCLE_MAX)) begin
				reg_cmd = hwmc_pkg::CMD_SET240;
				allow_n = 1'b0;
			end else begin
				allow_n = allow_q;
			end

			unique case (mode_q)
				ST_INIT: begin
					stopped_n = 1'b1;
					if (regulate) begin
						mode_cmd = hwmc_pkg::CMD_SET240;
					end
					element_n = 1'b0;
					offset_n  = ostart_x[15:0];
					unknown_n = 1'b0;
					mode_n    = ST_IDLE;
				end
				ST_IDLE: begin
					if (item.compressor_running) begin
						run_sec_n = '0;
						stopped_n = 1'b0;
						if (regulate) begin
							mode_cmd = hwmc_pkg::CMD_SET1;
						end
						mode_n = ST_RUN;
					end
				end
				ST_RUN, ST_ELEM: begin
					// offset tracking
					if (buf_x >= sp_x) begin
						offset_n  = '0;
						unknown_n = 1'b0;
					end else if (!unknown_q && (offset_q != '0) &&
					             (ret_x >= sp_x + off_x - hwmc_pkg::NEAR_MARGIN)) begin
						offset_n = hwmc_pkg::sat16(off_x + step_x);
					end

					if (!item.compressor_running && !item.defrost_active) begin
						element_n = 1'b0;
						stopped_n = 1'b1;
						if (regulate) begin
							mode_cmd = hwmc_pkg::CMD_SET240;
						end
						unknown_n = 1'b1;
						mode_n    = ST_IDLE;
					end else if ((mode_q == ST_RUN) && !stopped_q &&
					             (CMP_W'(run_sec_inc) >= CMP_W'(cfg.delay))) begin
						element_n = 1'b1;
						stopped_n = 1'b1;
						mode_n    = ST_ELEM;
					end
				end
				default: begin
					mode_n = mode_q;
				end
			endcase
		end

		res.heating_setpoint   = hwmc_pkg::sat16(sp_sum);
		res.element_on         = element_n;
		res.mode               = mode_n;
		res.regulation_command = reg_cmd;
		res.mode_command       = mode_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= ST_INIT;
			element_q  <= 1'b0;
			offset_q   <= {{6{hwmc_pkg::CFG_RESET.offset_start[9]}},
			               hwmc_pkg::CFG_RESET.offset_start};
			unknown_q  <= 1'b0;
			run_sec_q  <= '0;
			stopped_q  <= 1'b0;
			prev_dip_q <= 1'b0;
			allow_q    <= 1'b0;
		end else if (step_en) begin
			mode_q     <= mode_n;
			element_q  <= element_n;
			offset_q   <= offset_n;
			unknown_q  <= unknown_n;
			run_sec_q  <= run_sec_n;
			stopped_q  <= stopped_n;
			prev_dip_q <= prev_dip_n;
			allow_q    <= allow_n;
		end
	end

	a_elem_mode: assert property (@(posedge clk) disable iff (!arst_n)
		element_q == (mode_q == ST_ELEM))
		else $error("element flag and mode disagree");

	a_no_reinit: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != ST_INIT) |=> (mode_q != ST_INIT))
		else $error("init mode re-entered");

	a_elem_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == ST_ELEM) |-> stopped_q)
		else $error("run timer active with element on");

	a_invalid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && !item.buffer_temp_valid) |=> ($stable(mode_q) && $stable(offset_q)))
		else $error("state changed on invalid buffer temperature");

endmodule
`default_nettype wire

@@ tb/hwmc_tick_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hot water mode controller tick checker
// Watches the register port and both beat channels. Keeps its own copy of the
// controller state, predicts each result when an input beat is accepted, and
// compares each output beat, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module hwmc_tick_check import hwmc_pkg::*; #(
	parameter int COUNTER_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [11:0] buffer_temp,
	input  logic        buffer_temp_valid,
	input  logic [11:0] return_temp,
	input  logic        compressor_running,
	input  logic        defrost_active,
	input  logic        dip_switch,
	input  logic [7:0]  present_cycle,
	input  logic        decade_tick,
	input  logic        second_tick,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [15:0] heating_setpoint,
	input  logic        element_on,
	input  logic [1:0]  mode,
	input  logic [1:0]  regulation_command,
	input  logic [1:0]  mode_command,
	output int          errors,
	output int          outstanding,
	output int          results_seen,
	output logic [3:0]  modes_seen
);

	typedef enum logic [1:0] {
		MODE_INIT    = 2'd0,
		MODE_IDLE    = 2'd1,
		MODE_RUN     = 2'd2,
		MODE_ELEMENT = 2'd3
	} mode_e;

	localparam longint RUN_MAX = (64'd1 << COUNTER_BITS) - 1;

	int     sp_cfg, delta_cfg, ofs_start_cfg, step_cfg, delay_cfg;
	mode_e  mode_q;
	bit     elem_q, ofs_unknown, timer_stop, last_dip, change_ok;
	int     offset_q;
	longint run_secs;
	res_t   ctrl_out_q[$];

	function automatic int clamp16(input int v);
		if (v > 32767) begin
			return 32767;
		end else if (v < -32768) begin
			return -32768;
		end
		return v;
	endfunction

	task automatic control_tick(input item_t it, output res_t r);
		int   tank, ret_w, sp_out;
		bit   regulate;
		cmd_t rcmd, mcmd;
		tank = int'($signed(it.buffer_temp));
		ret_w = int'($signed(it.return_temp));
		regulate = !it.dip_switch;
		rcmd = CMD_NONE;
		mcmd = CMD_NONE;
		if (it.second_tick && !timer_stop && run_secs < RUN_MAX) begin
			run_secs++;
		end
		sp_out = clamp16(sp_cfg + (ofs_unknown ? 0 : offset_q));
		if (it.buffer_temp_valid) begin
			if (it.dip_switch != last_dip) begin
				last_dip = it.dip_switch;
				if (it.dip_switch) begin
					rcmd = CMD_SET10;
				end
			end
			if (it.decade_tick) begin
				change_ok = 1'b1;
			end else if (!regulate) begin
				change_ok = 1'b0;
			end else if (change_ok && tank <= sp_cfg - delta_cfg &&
					it.present_cycle != CYCLE_ONE) begin
				rcmd = CMD_SET1;
				change_ok = 1'b0;
			end else if (change_ok && tank >= sp_cfg && it.present_cycle != CYCLE_MAX) begin
				rcmd = CMD_SET240;
				change_ok = 1'b0;
			end
			case (mode_q)
			MODE_INIT: begin
				timer_stop = 1'b1;
				if (regulate) begin
					mcmd = CMD_SET240;
				end
				elem_q = 1'b0;
				offset_q = ofs_start_cfg;
				ofs_unknown = 1'b0;
				mode_q = MODE_IDLE;
			end
			MODE_IDLE: begin
				if (it.compressor_running) begin
					run_secs = 0;
					timer_stop = 1'b0;
					if (regulate) begin
						mcmd = CMD_SET1;
					end
					mode_q = MODE_RUN;
				end
			end
			default: begin
				// offset: cleared at setpoint, else stepped when return water is near
				if (tank >= sp_cfg) begin
					offset_q = 0;
					ofs_unknown = 1'b0;
				end else if (!ofs_unknown && offset_q != 0 &&
						ret_w >= sp_cfg + offset_q - int'(NEAR_MARGIN)) begin
					offset_q = clamp16(offset_q + step_cfg);
				end
				if (!it.compressor_running && !it.defrost_active) begin
					elem_q = 1'b0;
					timer_stop = 1'b1;
					if (regulate) begin
						mcmd = CMD_SET240;
					end
					ofs_unknown = 1'b1;
					mode_q = MODE_IDLE;
				end else if (mode_q == MODE_RUN && !timer_stop &&
						run_secs >= longint'(delay_cfg)) begin
					elem_q = 1'b1;
					timer_stop = 1'b1;
					mode_q = MODE_ELEMENT;
				end
			end
			endcase
		end
		r.heating_setpoint = 16'(sp_out);
		r.element_on = elem_q;
		r.mode = mode_q;
		r.regulation_command = rcmd;
		r.mode_command = mcmd;
	endtask

	task automatic check_field(input string name, input logic [15:0] want_v,
			input logic [15:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0h, got %0h", name, want_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		item_t beat;
		res_t  want;
		if (!arst_n) begin
			sp_cfg = int'($signed(CFG_RESET.setpoint));
			delta_cfg = int'(CFG_RESET.delta);
			ofs_start_cfg = int'($signed(CFG_RESET.offset_start));
			step_cfg = int'(CFG_RESET.step);
			delay_cfg = int'(CFG_RESET.delay);
			mode_q = MODE_INIT;
			elem_q = 1'b0;
			offset_q = ofs_start_cfg;
			ofs_unknown = 1'b0;
			run_secs = 0;
			timer_stop = 1'b0;
			last_dip = 1'b0;
			change_ok = 1'b0;
			ctrl_out_q.delete();
			errors = 0;
			outstanding = 0;
			results_seen = 0;
			modes_seen = '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				CFG_SETPOINT:     sp_cfg = int'($signed(cfg_wdata[11:0]));
				CFG_DELTA:        delta_cfg = int'(cfg_wdata[8:0]);
				CFG_OFFSET_START: ofs_start_cfg = int'($signed(cfg_wdata[9:0]));
				CFG_STEP:         step_cfg = int'(cfg_wdata[7:0]);
				CFG_DELAY:        delay_cfg = int'(cfg_wdata);
				default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				beat = {buffer_temp, buffer_temp_valid, return_temp, compressor_running,
					defrost_active, dip_switch, present_cycle, decade_tick, second_tick};
				control_tick(beat, want);
				ctrl_out_q.push_back(want);
				outstanding++;
			end
			if (out_valid && !out_stall) begin
				if (ctrl_out_q.size() == 0) begin
					$error("output beat with no prediction pending");
					errors++;
				end else begin
					want = ctrl_out_q.pop_front();
					outstanding--;
					results_seen++;
					modes_seen[want.mode] = 1'b1;
					check_field("heating_setpoint", want.heating_setpoint, heating_setpoint);
					check_field("element_on", 16'(want.element_on), 16'(element_on));
					check_field("mode", 16'(want.mode), 16'(mode));
					check_field("regulation_command", 16'(want.regulation_command),
						16'(regulation_command));
					check_field("mode_command", 16'(want.mode_command), 16'(mode_command));
				end
			end
		end
	end

endmodule

@@ tb/tb_hot_water_mode_controller_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hot water mode controller testbench
// Drives control ticks in bursts through six register settings (opening,
// default, both extremes, random), with a directed opening sequence, random
// output stalls and long hold-offs, one early on. The tick checker predicts
// and compares every beat; this module makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_hot_water_mode_controller_unit;
	import hwmc_pkg::*;

	localparam int COUNTER_BITS = 16;
	localparam int NUM_SETTINGS = 6;
	localparam int PHASE_TICKS = 125;
	localparam int SETTLE = 4;
	localparam int LIMIT = 200000;
	localparam logic [7:0] CYCLE_TEN = 8'd10;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = CFG_SETPOINT;
	logic [15:0]        cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [11:0] buffer_temp = '0;
	logic               buffer_temp_valid = 1'b0;
	logic signed [11:0] return_temp = '0;
	logic               compressor_running = 1'b0;
	logic               defrost_active = 1'b0;
	logic               dip_switch = 1'b0;
	logic [7:0]         present_cycle = '0;
	logic               decade_tick = 1'b0;
	logic               second_tick = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [15:0] heating_setpoint;
	logic               element_on;
	logic [1:0]         mode;
	logic [1:0]         regulation_command;
	logic [1:0]         mode_command;

	int         errors, outstanding, results_seen;
	logic [3:0] modes_seen;
	int         cycle_count = 0;
	int         sent = 0;
	int         burst_left = 0;
	int         sp_now = 500;
	int         delta_now = 50;
	bit         comp_on = 1'b1;
	bit         dip_on = 1'b0;

	always #10 clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	hot_water_mode_controller_unit #(.COUNTER_BITS(COUNTER_BITS)) uut (.*);

	hwmc_tick_check #(.COUNTER_BITS(COUNTER_BITS)) u_check (.*);

	function automatic item_t tick(input bit v, input int tank, input int ret, input bit comp,
			input bit defr, input bit dip, input int cyc, input bit dec, input bit sec);
		item_t t;
		t.buffer_temp = 12'(tank);
		t.buffer_temp_valid = v;
		t.return_temp = 12'(ret);
		t.compressor_running = comp;
		t.defrost_active = defr;
		t.dip_switch = dip;
		t.present_cycle = 8'(cyc);
		t.decade_tick = dec;
		t.second_tick = sec;
		return t;
	endfunction

	function automatic logic [11:0] temp_in(input int lo, input int span);
		int v;
		v = lo + int'($urandom_range(0, span));
		if (v < -400) begin
			v = -400;
		end else if (v > 1200) begin
			v = 1200;
		end
		return 12'(v);
	endfunction

	task automatic make_tick(output item_t it);
		if ($urandom_range(0, 7) == 0) begin
			comp_on = !comp_on;
		end
		if ($urandom_range(0, dip_on ? 5 : 24) == 0) begin
			dip_on = !dip_on;
		end
		it.buffer_temp_valid = ($urandom_range(0, 9) != 0);
		it.compressor_running = comp_on;
		it.defrost_active = ($urandom_range(0, 9) == 0);
		it.dip_switch = dip_on;
		case ($urandom_range(0, 3))
		0: it.present_cycle = CYCLE_ONE;
		1: it.present_cycle = CYCLE_TEN;
		2: it.present_cycle = CYCLE_MAX;
		default: it.present_cycle = 8'($urandom_range(0, 255));
		endcase
		it.decade_tick = ($urandom_range(0, 4) == 0);
		it.second_tick = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 9) < 7) begin
			it.buffer_temp = temp_in(sp_now - delta_now - 30, delta_now + 60);
		end else begin
			it.buffer_temp = temp_in(-400, 1600);
		end
		if ($urandom_range(0, 9) < 6) begin
			it.return_temp = temp_in(sp_now - 350, 700);
		end else begin
			it.return_temp = temp_in(-400, 1600);
		end
	endtask

	// holds the beat until accepted; bursts end in a short random gap
	task automatic offer(input item_t it);
		int gap;
		@(negedge clk);
		buffer_temp <= it.buffer_temp;
		buffer_temp_valid <= it.buffer_temp_valid;
		return_temp <= it.return_temp;
		compressor_running <= it.compressor_running;
		defrost_active <= it.defrost_active;
		dip_switch <= it.dip_switch;
		present_cycle <= it.present_cycle;
		decade_tick <= it.decade_tick;
		second_tick <= it.second_tick;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(0, 12);
			gap = $urandom_range(1, 6);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic apply_settings(input int sp, input int dl, input int os, input int st,
			input int dy);
		sp_now = sp;
		delta_now = dl;
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SETPOINT;
		cfg_wdata <= 16'(sp);
		@(negedge clk);
		cfg_index <= CFG_DELTA;
		cfg_wdata <= 16'(dl);
		@(negedge clk);
		cfg_index <= CFG_OFFSET_START;
		cfg_wdata <= 16'(os);
		@(negedge clk);
		cfg_index <= CFG_STEP;
		cfg_wdata <= 16'(st);
		@(negedge clk);
		cfg_index <= CFG_DELAY;
		cfg_wdata <= 16'(dy);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// receiver: segments of random stall density, one long hold-off early on
	initial begin
		int seg, len, pct;
		seg = 0;
		@(posedge arst_n);
		forever begin
			seg++;
			if (seg == 3 || $urandom_range(0, 15) == 0) begin
				len = $urandom_range(40, 70);
				pct = 100;
			end else begin
				len = $urandom_range(4, 40);
				case ($urandom_range(0, 3))
				0: pct = 0;
				1: pct = 25;
				2: pct = 50;
				default: pct = 80;
				endcase
			end
			repeat (len) begin
				@(negedge clk);
				out_stall <= ($urandom_range(0, 99) < pct);
			end
		end
	end

	initial begin
		wait (cycle_count >= LIMIT);
		$display("Timeout after %0d cycles", LIMIT);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		item_t it;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < NUM_SETTINGS; p++) begin
			case (p)
			0: apply_settings(500, 50, -300, 20, 2);
			1: apply_settings(-400, 0, 300, 0, 0);
			2: apply_settings(1200, 300, 0, 200, 65534);
			4: apply_settings(500, 50, 0, 20, 7200);
			default: apply_settings(int'($urandom_range(0, 1600)) - 400,
				$urandom_range(0, 300), int'($urandom_range(0, 600)) - 300,
				$urandom_range(0, 200), $urandom_range(0, 40));
			endcase
			if (p == 0) begin
				// invalid beat before init, then init, start, regulation, offset, element
				offer(tick(0, -400, 1200, 1, 1, 1, 255, 1, 1));
				offer(tick(1, 450, 300, 0, 0, 0, 0, 0, 0));
				offer(tick(1, 450, 300, 1, 0, 0, 10, 1, 1));
				offer(tick(1, 400, 1200, 1, 0, 0, 240, 0, 1));
				offer(tick(1, 1200, -400, 1, 0, 0, 1, 1, 1));
				offer(tick(1, 600, 500, 1, 0, 0, 10, 0, 1));
				offer(tick(1, 499, 480, 0, 1, 1, 240, 0, 0));
				offer(tick(1, 300, 300, 0, 0, 1, 240, 1, 1));
				offer(tick(1, 300, 300, 0, 0, 0, 240, 0, 0));
				offer(tick(1, 300, 600, 1, 0, 0, 1, 0, 1));
				offer(tick(0, 1200, 1200, 0, 0, 0, 1, 0, 1));
				offer(tick(1, 450, 1200, 1, 0, 0, 1, 1, 1));
				offer(tick(1, 500, 1200, 1, 0, 0, 1, 0, 0));
				offer(tick(1, -400, -400, 0, 0, 0, 255, 0, 0));
				offer(tick(1, -400, -400, 0, 0, 0, 255, 1, 0));
				offer(tick(1, -400, -400, 0, 0, 0, 255, 0, 0));
				offer(tick(1, 1200, 1200, 1, 1, 0, 0, 1, 1));
			end
			repeat (PHASE_TICKS) begin
				make_tick(it);
				offer(it);
			end
			@(negedge clk);
			in_valid <= 1'b0;
			while (outstanding != 0) @(negedge clk);
			repeat (SETTLE) @(negedge clk);
		end
		$display("Run covered %0d beats over %0d register settings, %0d results checked",
			sent, NUM_SETTINGS, results_seen);
		$display("Modes reached (init..element, one bit each, msb element): %b", modes_seen);
		if (errors == 0 && outstanding == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

@@ hot_water_mode_controller_unit.f @@
hdl/hwmc_pkg.sv
hdl/hwmc_ctrl.sv
hdl/hot_water_mode_controller_unit.sv
tb/hwmc_tick_check.sv
tb/tb_hot_water_mode_controller_unit.sv
